@@ hdl/lav_pkg.sv @@
// Shared types and constants for the look-at view matrix block.
// Depends on nothing; every other file imports it.
package lav_pkg;

  // Aligned vectors keep their largest magnitude in [2^29, 2^30).
  localparam int AM        = 30;
  localparam int AW        = AM + 1;
  localparam int ALIGN_MSB = 29;

  // Sum of three squares of aligned values and its integer square root.
  localparam int SQ_W   = 2 * AM + 2;
  localparam int ROOT_W = SQ_W / 2;
  localparam int REM_W  = ROOT_W + 2;

  localparam int OUT_W = 32;
  localparam logic [1:0] LAST_ROW = 2'd3;

  // Valid bit and running "no zero-length vector seen" flag of one item.
  typedef struct packed {
    logic valid;
    logic ok;
  } lav_flag_t;

endpackage

@@ hdl/lav_norm.sv @@
// Pipelined vector alignment and, optionally, normalization to unit length.
// Depends on lav_pkg.
module lav_norm
  import lav_pkg::*;
#(
  parameter int IW   = 32,
  parameter int FB   = 16,
  parameter int SW   = 1,
  parameter bit NORM = 1'b1
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  lav_flag_t          in_flag,
  input  logic [2:0][IW-1:0] in_c,
  input  logic [SW-1:0]      in_side,
  output lav_flag_t          out_flag,
  output logic [2:0][AW-1:0] out_r,
  output logic [SW-1:0]      out_side
);

  localparam int IXW = $clog2(IW);

  // Stage 1: magnitudes and signs.
  logic               a1_v_r, a1_ok_r;
  logic [2:0][IW-1:0] a1_mag_r;
  logic [2:0]         a1_neg_r;
  logic [SW-1:0]      a1_side_r;
  logic [2:0][IW-1:0] mag_nxt;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      mag_nxt[k] = in_c[k][IW-1] ? (~in_c[k] + IW'(1)) : in_c[k];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a1_v_r <= 1'b0;
    end else if (en) begin
      a1_v_r    <= in_flag.valid;
      a1_ok_r   <= in_flag.ok;
      a1_mag_r  <= mag_nxt;
      for (int k = 0; k < 3; k++) a1_neg_r[k] <= in_c[k][IW-1];
      a1_side_r <= in_side;
    end
  end

  // Stage 2: largest magnitude.
  logic               a2_v_r, a2_ok_r;
  logic [IW-1:0]      a2_m_r, m_nxt;
  logic [2:0][IW-1:0] a2_mag_r;
  logic [2:0]         a2_neg_r;
  logic [SW-1:0]      a2_side_r;

  always_comb begin
    m_nxt = a1_mag_r[0];
    if (a1_mag_r[1] > m_nxt) m_nxt = a1_mag_r[1];
    if (a1_mag_r[2] > m_nxt) m_nxt = a1_mag_r[2];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a2_v_r <= 1'b0;
    end else if (en) begin
      a2_v_r    <= a1_v_r;
      a2_ok_r   <= a1_ok_r;
      a2_m_r    <= m_nxt;
      a2_mag_r  <= a1_mag_r;
      a2_neg_r  <= a1_neg_r;
      a2_side_r <= a1_side_r;
    end
  end

  // Stage 3: position of the leading one of the largest magnitude.
  logic               a3_v_r, a3_ok_r;
  logic [IXW-1:0]     a3_p_r, p_nxt;
  logic [2:0][IW-1:0] a3_mag_r;
  logic [2:0]         a3_neg_r;
  logic [SW-1:0]      a3_side_r;

  always_comb begin
    p_nxt = '0;
    for (int i = 0; i < IW; i++) begin
      if (a2_m_r[i]) p_nxt = IXW'(i);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a3_v_r <= 1'b0;
    end else if (en) begin
      a3_v_r    <= a2_v_r;
      a3_ok_r   <= a2_ok_r && (a2_m_r != '0);
      a3_p_r    <= p_nxt;
      a3_mag_r  <= a2_mag_r;
      a3_neg_r  <= a2_neg_r;
      a3_side_r <= a2_side_r;
    end
  end

  // Stage 4: shift all three magnitudes by the same amount.
  logic               a4_v_r, a4_ok_r;
  logic [2:0][AM-1:0] a4_mag_r, al_nxt;
  logic [2:0]         a4_neg_r;
  logic [SW-1:0]      a4_side_r;

  always_comb begin
    logic [IW+AM-1:0] wide;
    logic [IW+AM-1:0] sh;
    for (int k = 0; k < 3; k++) begin
      wide = {{AM{1'b0}}, a3_mag_r[k]};
      if (int'(a3_p_r) >= ALIGN_MSB) begin
        sh = wide >> (int'(a3_p_r) - ALIGN_MSB);
      end else begin
        sh = wide << (ALIGN_MSB - int'(a3_p_r));
      end
      al_nxt[k] = sh[AM-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a4_v_r <= 1'b0;
    end else if (en) begin
      a4_v_r    <= a3_v_r;
      a4_ok_r   <= a3_ok_r;
      a4_mag_r  <= al_nxt;
      a4_neg_r  <= a3_neg_r;
      a4_side_r <= a3_side_r;
    end
  end

  if (NORM) begin : g_norm
    localparam int DW = ROOT_W + 1 + FB;
    localparam int QW = FB + 1;
    localparam int ND = FB + 1;

    // Stage 5: squares.
    logic                 s5_v_r, s5_ok_r;
    logic [2:0][AM-1:0]   s5_mag_r;
    logic [2:0][2*AM-1:0] s5_sq_r;
    logic [2:0]           s5_neg_r;
    logic [SW-1:0]        s5_side_r;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        s5_v_r <= 1'b0;
      end else if (en) begin
        s5_v_r   <= a4_v_r;
        s5_ok_r  <= a4_ok_r;
        s5_mag_r <= a4_mag_r;
        for (int k = 0; k < 3; k++) s5_sq_r[k] <= a4_mag_r[k] * a4_mag_r[k];
        s5_neg_r  <= a4_neg_r;
        s5_side_r <= a4_side_r;
      end
    end

    // Square root, one result bit per stage. Entry 0 holds the sum.
    logic                 sq_v_r    [ROOT_W+1];
    logic                 sq_ok_r   [ROOT_W+1];
    logic [SQ_W-1:0]      sq_x_r    [ROOT_W+1];
    logic [REM_W-1:0]     sq_rem_r  [ROOT_W+1];
    logic [ROOT_W-1:0]    sq_root_r [ROOT_W+1];
    logic [2:0][AM-1:0]   sq_mag_r  [ROOT_W+1];
    logic [2:0]           sq_neg_r  [ROOT_W+1];
    logic [SW-1:0]        sq_side_r [ROOT_W+1];

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        sq_v_r[0] <= 1'b0;
      end else if (en) begin
        sq_v_r[0]    <= s5_v_r;
        sq_ok_r[0]   <= s5_ok_r;
        sq_x_r[0]    <= SQ_W'(s5_sq_r[0]) + SQ_W'(s5_sq_r[1]) + SQ_W'(s5_sq_r[2]);
        sq_rem_r[0]  <= '0;
        sq_root_r[0] <= '0;
        sq_mag_r[0]  <= s5_mag_r;
        sq_neg_r[0]  <= s5_neg_r;
        sq_side_r[0] <= s5_side_r;
      end
    end

    for (genvar s = 1; s <= ROOT_W; s++) begin : g_sqrt
      logic [REM_W-1:0] rt, trial;
      assign rt    = {sq_rem_r[s-1][REM_W-3:0], sq_x_r[s-1][SQ_W-1 -: 2]};
      assign trial = {sq_root_r[s-1], 2'b01};

      always_ff @(posedge clk) begin
        if (!rst_n) begin
          sq_v_r[s] <= 1'b0;
        end else if (en) begin
          sq_v_r[s]  <= sq_v_r[s-1];
          sq_ok_r[s] <= sq_ok_r[s-1];
          sq_x_r[s]  <= sq_x_r[s-1] << 2;
          if (rt >= trial) begin
            sq_rem_r[s]  <= rt - trial;
            sq_root_r[s] <= {sq_root_r[s-1][ROOT_W-2:0], 1'b1};
          end else begin
            sq_rem_r[s]  <= rt;
            sq_root_r[s] <= {sq_root_r[s-1][ROOT_W-2:0], 1'b0};
          end
          sq_mag_r[s]  <= sq_mag_r[s-1];
          sq_neg_r[s]  <= sq_neg_r[s-1];
          sq_side_r[s] <= sq_side_r[s-1];
        end
      end
    end

    // Long division, one quotient bit per stage. Entry 0 holds the
    // numerators with half the length added for rounding.
    logic               dv_v_r    [ND+1];
    logic               dv_ok_r   [ND+1];
    logic [ROOT_W-1:0]  dv_len_r  [ND+1];
    logic [2:0][DW-1:0] dv_rem_r  [ND+1];
    logic [2:0][QW-1:0] dv_q_r    [ND+1];
    logic [2:0]         dv_neg_r  [ND+1];
    logic [SW-1:0]      dv_side_r [ND+1];

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_v_r[0] <= 1'b0;
      end else if (en) begin
        dv_v_r[0]   <= sq_v_r[ROOT_W];
        dv_ok_r[0]  <= sq_ok_r[ROOT_W];
        dv_len_r[0] <= sq_root_r[ROOT_W];
        for (int k = 0; k < 3; k++) begin
          dv_rem_r[0][k] <= (DW'(sq_mag_r[ROOT_W][k]) << FB)
                            + DW'(sq_root_r[ROOT_W] >> 1);
        end
        dv_q_r[0]    <= '0;
        dv_neg_r[0]  <= sq_neg_r[ROOT_W];
        dv_side_r[0] <= sq_side_r[ROOT_W];
      end
    end

    for (genvar s = 1; s <= ND; s++) begin : g_div
      localparam int J = ND - s;
      logic [DW-1:0] dsr;
      assign dsr = DW'(dv_len_r[s-1]) << J;

      always_ff @(posedge clk) begin
        if (!rst_n) begin
          dv_v_r[s] <= 1'b0;
        end else if (en) begin
          dv_v_r[s]   <= dv_v_r[s-1];
          dv_ok_r[s]  <= dv_ok_r[s-1];
          dv_len_r[s] <= dv_len_r[s-1];
          for (int k = 0; k < 3; k++) begin
            if (dv_rem_r[s-1][k] >= dsr) begin
              dv_rem_r[s][k] <= dv_rem_r[s-1][k] - dsr;
              dv_q_r[s][k]   <= {dv_q_r[s-1][k][QW-2:0], 1'b1};
            end else begin
              dv_rem_r[s][k] <= dv_rem_r[s-1][k];
              dv_q_r[s][k]   <= {dv_q_r[s-1][k][QW-2:0], 1'b0};
            end
          end
          dv_neg_r[s]  <= dv_neg_r[s-1];
          dv_side_r[s] <= dv_side_r[s-1];
        end
      end
    end

    // Output stage: apply the signs.
    lav_flag_t          o_flag_r;
    logic [2:0][AW-1:0] o_r_r;
    logic [SW-1:0]      o_side_r;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        o_flag_r.valid <= 1'b0;
      end else if (en) begin
        o_flag_r.valid <= dv_v_r[ND];
        o_flag_r.ok    <= dv_ok_r[ND];
        for (int k = 0; k < 3; k++) begin
          if (dv_neg_r[ND][k]) begin
            o_r_r[k] <= ~{{(AW-QW){1'b0}}, dv_q_r[ND][k]} + AW'(1);
          end else begin
            o_r_r[k] <= {{(AW-QW){1'b0}}, dv_q_r[ND][k]};
          end
        end
        o_side_r <= dv_side_r[ND];
      end
    end

    assign out_flag = o_flag_r;
    assign out_r    = o_r_r;
    assign out_side = o_side_r;

  end else begin : g_align

    always_comb begin
      for (int k = 0; k < 3; k++) begin
        out_r[k] = a4_neg_r[k] ? (~{1'b0, a4_mag_r[k]} + AW'(1)) : {1'b0, a4_mag_r[k]};
      end
    end
    assign out_flag.valid = a4_v_r;
    assign out_flag.ok    = a4_ok_r;
    assign out_side       = a4_side_r;

  end

endmodule

@@ hdl/look_at_view_matrix.sv @@
// Look-at view matrix top level: input register, three normalizers, cross
// products, translation row and the four-row output serializer. Depends on lav_pkg, lav_norm.

// Each accepted item (eye, target and up direction in signed fixed point with
// FRAC_BITS fraction bits) yields four result items, rows 0 to 3 of the view
// matrix, in order: rows 0 to 2 carry (u_k, v_k, n_k, 0) and row 3 carries
// (-eye.u, -eye.v, -eye.n, 1.0). When eye equals target, up is zero or up is
// parallel to the view direction, degenerate is set on all four rows and every
// element is zero. The datapath is a fully pipelined chain that takes a new
// item in any cycle in which in_ready is high: an up-vector aligner, three
// normalizers (each with a one-bit-per-stage square root and
// one-bit-per-stage dividers) and the cross-product and dot-product stages
// between them. The sustained rate is set by the output serializer, which
// presents one row per cycle while out_ready is high, from a single result
// register; while it works through an item, the pipeline keeps taking new
// items until the next finished item reaches its last stage.
module look_at_view_matrix
  import lav_pkg::*;
#(
  parameter int COORD_WIDTH = 32,
  parameter int FRAC_BITS   = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [COORD_WIDTH-1:0] in_eye_x,
  input  logic signed [COORD_WIDTH-1:0] in_eye_y,
  input  logic signed [COORD_WIDTH-1:0] in_eye_z,
  input  logic signed [COORD_WIDTH-1:0] in_target_x,
  input  logic signed [COORD_WIDTH-1:0] in_target_y,
  input  logic signed [COORD_WIDTH-1:0] in_target_z,
  input  logic signed [COORD_WIDTH-1:0] in_up_dir_x,
  input  logic signed [COORD_WIDTH-1:0] in_up_dir_y,
  input  logic signed [COORD_WIDTH-1:0] in_up_dir_z,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [1:0]                    out_row_index,
  output logic signed [OUT_W-1:0]       out_elem_0,
  output logic signed [OUT_W-1:0]       out_elem_1,
  output logic signed [OUT_W-1:0]       out_elem_2,
  output logic signed [OUT_W-1:0]       out_elem_3,
  output logic                          out_last_row,
  output logic                          out_degenerate
);

  localparam int CW   = COORD_WIDTH;
  localparam int FB   = FRAC_BITS;
  localparam int NW   = FB + 2;            // a unit component, |x| <= 2^FB
  localparam int DIW  = CW + 1;            // eye - target
  localparam int TW1  = AW + NW + 1;       // up x n
  localparam int TW2  = 2 * NW + 1;        // n x u
  localparam int LO   = CW / 2;            // eye split for the dot products
  localparam int HW   = CW - LO;
  localparam int PLW  = LO + 1 + NW;
  localparam int PHW  = HW + NW;
  localparam int PKW  = CW + NW;
  localparam int STW  = PKW + 2;
  localparam int FLW  = STW - FB;
  localparam int NGW  = (FLW + 1 > OUT_W + 1) ? FLW + 1 : OUT_W + 1;
  localparam int SW1  = 3 * CW + 3 * DIW;
  localparam int SW2  = 3 * CW + 3 * AW;
  localparam int SW3  = 3 * CW + 3 * NW;
  localparam int SW4  = 3 * CW + 6 * NW;

  localparam logic signed [NGW-1:0] SAT_MAX = NGW'(32'sh7fffffff);
  localparam logic signed [NGW-1:0] SAT_MIN = -SAT_MAX - NGW'(1);

  // The whole chain advances together unless the last stage holds an item
  // that the serializer cannot take yet.
  logic en;
  logic ser_load;

  // ---------------------------------------------------------------------------
  // Input register: eye, view offset eye - target, up.
  // ---------------------------------------------------------------------------
  logic                t0_v_r;
  logic [2:0][CW-1:0]  t0_eye_r;
  logic [2:0][DIW-1:0] t0_d_r;
  logic [2:0][CW-1:0]  t0_up_r;

  assign in_ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      t0_v_r <= 1'b0;
    end else if (en) begin
      t0_v_r      <= in_valid;
      t0_eye_r[0] <= in_eye_x;
      t0_eye_r[1] <= in_eye_y;
      t0_eye_r[2] <= in_eye_z;
      t0_d_r[0]   <= DIW'(in_eye_x) - DIW'(in_target_x);
      t0_d_r[1]   <= DIW'(in_eye_y) - DIW'(in_target_y);
      t0_d_r[2]   <= DIW'(in_eye_z) - DIW'(in_target_z);
      t0_up_r[0]  <= in_up_dir_x;
      t0_up_r[1]  <= in_up_dir_y;
      t0_up_r[2]  <= in_up_dir_z;
    end
  end

  // ---------------------------------------------------------------------------
  // Align the up vector; its length does not matter for u.
  // ---------------------------------------------------------------------------
  lav_flag_t           f0, f1;
  logic [2:0][AW-1:0]  upa1;
  logic [2:0][CW-1:0]  eye1;
  logic [2:0][DIW-1:0] d1;
  logic [SW1-1:0]      side1;

  assign f0.valid = t0_v_r;
  assign f0.ok    = 1'b1;

  lav_norm #(.IW(CW), .FB(FB), .SW(SW1), .NORM(1'b0)) u_up_align (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_flag  (f0),
    .in_c     (t0_up_r),
    .in_side  ({t0_eye_r, t0_d_r}),
    .out_flag (f1),
    .out_r    (upa1),
    .out_side (side1)
  );

  assign {eye1, d1} = side1;

  // ---------------------------------------------------------------------------
  // n = normalize(eye - target).
  // ---------------------------------------------------------------------------
  lav_flag_t          f2;
  logic [2:0][AW-1:0] n2;
  logic [2:0][CW-1:0] eye2;
  logic [2:0][AW-1:0] upa2;
  logic [SW2-1:0]     side2;

  lav_norm #(.IW(DIW), .FB(FB), .SW(SW2), .NORM(1'b1)) u_norm_n (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_flag  (f1),
    .in_c     (d1),
    .in_side  ({eye1, upa1}),
    .out_flag (f2),
    .out_r    (n2),
    .out_side (side2)
  );

  assign {eye2, upa2} = side2;

  // ---------------------------------------------------------------------------
  // up x n over two stages: products, then differences.
  // ---------------------------------------------------------------------------
  logic                     x1_v_r, x1_ok_r;
  logic signed [AW+NW-1:0]  x1_p_r [6];
  logic [2:0][CW-1:0]       x1_eye_r;
  logic [2:0][NW-1:0]       x1_n_r;
  logic signed [AW-1:0]     ca [3];
  logic signed [NW-1:0]     cb [3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      ca[k] = $signed(upa2[k]);
      cb[k] = $signed(n2[k][NW-1:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x1_v_r <= 1'b0;
    end else if (en) begin
      x1_v_r    <= f2.valid;
      x1_ok_r   <= f2.ok;
      x1_p_r[0] <= ca[1] * cb[2];
      x1_p_r[1] <= ca[2] * cb[1];
      x1_p_r[2] <= ca[2] * cb[0];
      x1_p_r[3] <= ca[0] * cb[2];
      x1_p_r[4] <= ca[0] * cb[1];
      x1_p_r[5] <= ca[1] * cb[0];
      x1_eye_r  <= eye2;
      for (int k = 0; k < 3; k++) x1_n_r[k] <= n2[k][NW-1:0];
    end
  end

  lav_flag_t           x2_flag_r;
  logic [2:0][TW1-1:0] x2_t_r;
  logic [2:0][CW-1:0]  x2_eye_r;
  logic [2:0][NW-1:0]  x2_n_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x2_flag_r.valid <= 1'b0;
    end else if (en) begin
      x2_flag_r.valid <= x1_v_r;
      x2_flag_r.ok    <= x1_ok_r;
      for (int k = 0; k < 3; k++) begin
        x2_t_r[k] <= TW1'(x1_p_r[2*k]) - TW1'(x1_p_r[2*k+1]);
      end
      x2_eye_r <= x1_eye_r;
      x2_n_r   <= x1_n_r;
    end
  end

  // ---------------------------------------------------------------------------
  // u = normalize(up x n).
  // ---------------------------------------------------------------------------
  lav_flag_t          f3;
  logic [2:0][AW-1:0] u3;
  logic [2:0][CW-1:0] eye3;
  logic [2:0][NW-1:0] n3;
  logic [SW3-1:0]     side3;

  lav_norm #(.IW(TW1), .FB(FB), .SW(SW3), .NORM(1'b1)) u_norm_u (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_flag  (x2_flag_r),
    .in_c     (x2_t_r),
    .in_side  ({x2_eye_r, x2_n_r}),
    .out_flag (f3),
    .out_r    (u3),
    .out_side (side3)
  );

  assign {eye3, n3} = side3;

  // ---------------------------------------------------------------------------
  // n x u over two stages.
  // ---------------------------------------------------------------------------
  logic                     x3_v_r, x3_ok_r;
  logic signed [2*NW-1:0]   x3_p_r [6];
  logic [2:0][CW-1:0]       x3_eye_r;
  logic [2:0][NW-1:0]       x3_n_r, x3_u_r;
  logic signed [NW-1:0]     da [3];
  logic signed [NW-1:0]     db [3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      da[k] = $signed(n3[k]);
      db[k] = $signed(u3[k][NW-1:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x3_v_r <= 1'b0;
    end else if (en) begin
      x3_v_r    <= f3.valid;
      x3_ok_r   <= f3.ok;
      x3_p_r[0] <= da[1] * db[2];
      x3_p_r[1] <= da[2] * db[1];
      x3_p_r[2] <= da[2] * db[0];
      x3_p_r[3] <= da[0] * db[2];
      x3_p_r[4] <= da[0] * db[1];
      x3_p_r[5] <= da[1] * db[0];
      x3_eye_r  <= eye3;
      x3_n_r    <= n3;
      for (int k = 0; k < 3; k++) x3_u_r[k] <= u3[k][NW-1:0];
    end
  end

  lav_flag_t           x4_flag_r;
  logic [2:0][TW2-1:0] x4_t_r;
  logic [2:0][CW-1:0]  x4_eye_r;
  logic [2:0][NW-1:0]  x4_n_r, x4_u_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x4_flag_r.valid <= 1'b0;
    end else if (en) begin
      x4_flag_r.valid <= x3_v_r;
      x4_flag_r.ok    <= x3_ok_r;
      for (int k = 0; k < 3; k++) begin
        x4_t_r[k] <= TW2'(x3_p_r[2*k]) - TW2'(x3_p_r[2*k+1]);
      end
      x4_eye_r <= x3_eye_r;
      x4_n_r   <= x3_n_r;
      x4_u_r   <= x3_u_r;
    end
  end

  // ---------------------------------------------------------------------------
  // v = normalize(n x u).
  // ---------------------------------------------------------------------------
  lav_flag_t          f4;
  logic [2:0][AW-1:0] v4;
  logic [2:0][CW-1:0] eye4;
  logic [2:0][NW-1:0] n4, u4;
  logic [SW4-1:0]     side4;

  lav_norm #(.IW(TW2), .FB(FB), .SW(SW4), .NORM(1'b1)) u_norm_v (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_flag  (x4_flag_r),
    .in_c     (x4_t_r),
    .in_side  ({x4_eye_r, x4_n_r, x4_u_r}),
    .out_flag (f4),
    .out_r    (v4),
    .out_side (side4)
  );

  assign {eye4, n4, u4} = side4;

  // ---------------------------------------------------------------------------
  // Translation row. Each eye coordinate is split into a signed upper half
  // and an unsigned lower half so that no product exceeds the multiplier
  // budget. The dot product is exact; it is rounded half toward plus
  // infinity, negated and saturated. Basis order is u, v, n.
  // ---------------------------------------------------------------------------
  logic signed [NW-1:0] w4 [3][3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      w4[0][k] = $signed(u4[k]);
      w4[1][k] = $signed(v4[k][NW-1:0]);
      w4[2][k] = $signed(n4[k]);
    end
  end

  logic                     t1_v_r, t1_ok_r;
  logic signed [PLW-1:0]    t1_lo_r [3][3];
  logic signed [PHW-1:0]    t1_hi_r [3][3];
  logic [2:0][NW-1:0]       t1_u_r, t1_v2_r, t1_n_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      t1_v_r <= 1'b0;
    end else if (en) begin
      t1_v_r  <= f4.valid;
      t1_ok_r <= f4.ok;
      for (int w = 0; w < 3; w++) begin
        for (int k = 0; k < 3; k++) begin
          t1_lo_r[w][k] <= $signed({1'b0, eye4[k][LO-1:0]}) * w4[w][k];
          t1_hi_r[w][k] <= $signed(eye4[k][CW-1:LO]) * w4[w][k];
        end
      end
      t1_u_r <= u4;
      for (int k = 0; k < 3; k++) t1_v2_r[k] <= v4[k][NW-1:0];
      t1_n_r <= n4;
    end
  end

  logic                     t2_v_r, t2_ok_r;
  logic signed [PKW-1:0]    t2_p_r [3][3];
  logic [2:0][NW-1:0]       t2_u_r, t2_v2_r, t2_n_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      t2_v_r <= 1'b0;
    end else if (en) begin
      t2_v_r  <= t1_v_r;
      t2_ok_r <= t1_ok_r;
      for (int w = 0; w < 3; w++) begin
        for (int k = 0; k < 3; k++) begin
          t2_p_r[w][k] <= (PKW'(t1_hi_r[w][k]) <<< LO) + PKW'(t1_lo_r[w][k]);
        end
      end
      t2_u_r  <= t1_u_r;
      t2_v2_r <= t1_v2_r;
      t2_n_r  <= t1_n_r;
    end
  end

  logic                     t3_v_r, t3_ok_r;
  logic signed [STW-1:0]    t3_s_r [3];
  logic [2:0][NW-1:0]       t3_u_r, t3_v2_r, t3_n_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      t3_v_r <= 1'b0;
    end else if (en) begin
      t3_v_r  <= t2_v_r;
      t3_ok_r <= t2_ok_r;
      for (int w = 0; w < 3; w++) begin
        t3_s_r[w] <= STW'(t2_p_r[w][0]) + STW'(t2_p_r[w][1]) + STW'(t2_p_r[w][2])
                     + (STW'(1) <<< (FB - 1));
      end
      t3_u_r  <= t2_u_r;
      t3_v2_r <= t2_v2_r;
      t3_n_r  <= t2_n_r;
    end
  end

  // Last pipeline stage: the finished matrix of one item.
  logic                     l_v_r, l_ok_r;
  logic [2:0][NW-1:0]       l_u_r, l_v2_r, l_n_r;
  logic [2:0][OUT_W-1:0]    l_t_r;
  logic [2:0][OUT_W-1:0]    sat_nxt;

  always_comb begin
    logic signed [FLW-1:0] fl;
    logic signed [NGW-1:0] ng;
    for (int w = 0; w < 3; w++) begin
      fl = $signed(t3_s_r[w][STW-1:FB]);
      ng = -NGW'(fl);
      if (ng > SAT_MAX) begin
        sat_nxt[w] = SAT_MAX[OUT_W-1:0];
      end else if (ng < SAT_MIN) begin
        sat_nxt[w] = SAT_MIN[OUT_W-1:0];
      end else begin
        sat_nxt[w] = ng[OUT_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      l_v_r <= 1'b0;
    end else if (en) begin
      l_v_r  <= t3_v_r;
      l_ok_r <= t3_ok_r;
      l_u_r  <= t3_u_r;
      l_v2_r <= t3_v2_r;
      l_n_r  <= t3_n_r;
      l_t_r  <= sat_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Output serializer: four rows per accepted result item.
  // ---------------------------------------------------------------------------
  logic                  s_v_r, s_ok_r;
  logic [1:0]            s_row_r;
  logic [2:0][NW-1:0]    s_u_r, s_v2_r, s_n_r;
  logic [2:0][OUT_W-1:0] s_t_r;

  assign ser_load = !s_v_r || (out_ready && (s_row_r == LAST_ROW));
  assign en       = !l_v_r || ser_load;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s_v_r   <= 1'b0;
      s_row_r <= '0;
    end else if (ser_load) begin
      s_v_r   <= l_v_r;
      s_row_r <= '0;
      s_ok_r  <= l_ok_r;
      s_u_r   <= l_u_r;
      s_v2_r  <= l_v2_r;
      s_n_r   <= l_n_r;
      s_t_r   <= l_t_r;
    end else if (out_ready) begin
      s_row_r <= s_row_r + 2'd1;
    end
  end

  always_comb begin
    out_elem_0 = '0;
    out_elem_1 = '0;
    out_elem_2 = '0;
    out_elem_3 = '0;
    if (s_ok_r) begin
      case (s_row_r)
        2'd0, 2'd1, 2'd2: begin
          out_elem_0 = OUT_W'($signed(s_u_r[s_row_r]));
          out_elem_1 = OUT_W'($signed(s_v2_r[s_row_r]));
          out_elem_2 = OUT_W'($signed(s_n_r[s_row_r]));
        end
        default: begin
          out_elem_0 = $signed(s_t_r[0]);
          out_elem_1 = $signed(s_t_r[1]);
          out_elem_2 = $signed(s_t_r[2]);
          out_elem_3 = $signed(OUT_W'(1) << FB);
        end
      endcase
    end
  end

  assign out_valid      = s_v_r;
  assign out_row_index  = s_row_r;
  assign out_last_row   = (s_row_r == LAST_ROW);
  assign out_degenerate = !s_ok_r;

endmodule

@@ hdl/lav_checker.sv @@
// Port-level checks for the look-at view matrix block and the bind that
// attaches them. Depends on lav_pkg and look_at_view_matrix.
module lav_checker
  import lav_pkg::*;
#(
  parameter int FB = 16
) (
  input logic                    clk,
  input logic                    rst_n,
  input logic                    out_valid,
  input logic                    out_ready,
  input logic [1:0]              out_row_index,
  input logic signed [OUT_W-1:0] out_elem_0,
  input logic signed [OUT_W-1:0] out_elem_1,
  input logic signed [OUT_W-1:0] out_elem_2,
  input logic signed [OUT_W-1:0] out_elem_3,
  input logic                    out_last_row,
  input logic                    out_degenerate
);

  // A stalled row keeps its place in the matrix.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_row_index))
    else $error("row index changed under stall");

  // Rows of one matrix follow each other without a gap and share one flag.
  a_next_row: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_last_row |=>
      out_valid && (out_row_index == 2'($past(out_row_index) + 2'd1))
      && $stable(out_degenerate))
    else $error("rows of a matrix out of sequence");

  a_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_last_row == (out_row_index == LAST_ROW)))
    else $error("last row flag does not match row index");

  a_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_degenerate |->
      out_elem_0 == '0 && out_elem_1 == '0 && out_elem_2 == '0 && out_elem_3 == '0)
    else $error("degenerate row carries nonzero elements");

  a_corner: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last_row && !out_degenerate |-> out_elem_3 == (OUT_W'(1) << FB))
    else $error("homogeneous corner of the matrix is not one");

endmodule

bind look_at_view_matrix lav_checker #(.FB(FRAC_BITS)) u_lav_checker (.*);
